FILE: sv/cau_pkg.sv
// package for the complex arithmetic unit: operation codes
// no dependencies
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage
`default_nettype wire

FILE: sv/cau_if.sv
// valid/ready channel interface carrying a generic payload
// depends on nothing
`default_nettype none
interface cau_if #(
  parameter int unsigned PW = 8
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/complex_arithmetic_unit_top.sv
// Complex arithmetic unit: a +, -, * or / b on signed fixed-point complex numbers
// (DATA_WIDTH bits, FRAC_BITS fraction). One beat is accepted every cycle while
// the output is not stalled; each beat passes through three operand stages, the
// row of 2*DATA_WIDTH+FRAC_BITS+2 division cells (one quotient bit per cell)
// and the output register. A stalled result freezes the whole pipeline.
// Results saturate with overflow; divide by zero gives zero and div_zero.
// depends on cau_pkg, cau_if, cau_div_cell
`default_nettype none
module complex_arithmetic_unit_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cau_if.sink      in_i,
  cau_if.source    out_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W + 2;        // product width
  localparam int unsigned SW = PW + 1;           // sum of products
  localparam int unsigned NW = PW + FRAC_BITS;   // numerator magnitude width
  localparam int unsigned DW = PW + 1;           // denominator width
  localparam int unsigned NS = NW;               // divider cells
  localparam int unsigned L  = NS + 4;           // pipeline length

  // pipeline advances whenever the output register is empty or its result is being taken
  logic adv;
  assign adv = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  logic [L-1:0] vld_q;

  // stage 0: register operands
  logic [1:0] op0_q;
  logic signed [W-1:0] ar0_q, ai0_q, br0_q, bi0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op0_q <= in_i.data[1:0];
      ar0_q <= in_i.data[2 +: W];
      ai0_q <= in_i.data[2+W +: W];
      br0_q <= in_i.data[2+2*W +: W];
      bi0_q <= in_i.data[2+3*W +: W];
    end
  end

  // full-precision signed products of the operand parts
  logic signed [2*W-1:0] m_rr, m_ii, m_ri, m_ir, m_bb, m_cc;
  assign m_rr = ar0_q * br0_q;
  assign m_ii = ai0_q * bi0_q;
  assign m_ri = ar0_q * bi0_q;
  assign m_ir = ai0_q * br0_q;
  assign m_bb = br0_q * br0_q;
  assign m_cc = bi0_q * bi0_q;

  // stage 1: four cross products plus the two squares, and add/sub
  logic [1:0] op1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;
  logic signed [SW-1:0] as_re_q, as_im_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= op0_q;
      p_rr_q <= PW'(m_rr);
      p_ii_q <= PW'(m_ii);
      p_ri_q <= PW'(m_ri);
      p_ir_q <= PW'(m_ir);
      p_bb_q <= PW'(m_bb);
      p_cc_q <= PW'(m_cc);
      if (op0_q == cau_pkg::OP_SUB) begin
        as_re_q <= SW'(ar0_q) - SW'(br0_q);
        as_im_q <= SW'(ai0_q) - SW'(bi0_q);
      end else begin
        as_re_q <= SW'(ar0_q) + SW'(br0_q);
        as_im_q <= SW'(ai0_q) + SW'(bi0_q);
      end
    end
  end

  // stage 2: combine products into exact sums per operation
  logic [1:0] op2_q;
  logic signed [SW-1:0] s_re_q, s_im_q;
  logic [DW-1:0] den2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q  <= op1_q;
      den2_q <= DW'(p_bb_q) + DW'(p_cc_q);
      unique case (cau_pkg::op_e'(op1_q))
        cau_pkg::OP_MUL: begin
          s_re_q <= SW'(p_rr_q) - SW'(p_ii_q);
          s_im_q <= SW'(p_ri_q) + SW'(p_ir_q);
        end
        cau_pkg::OP_DIV: begin
          s_re_q <= SW'(p_rr_q) + SW'(p_ii_q);
          s_im_q <= SW'(p_ir_q) - SW'(p_ri_q);
        end
        default: begin
          s_re_q <= as_re_q;
          s_im_q <= as_im_q;
        end
      endcase
    end
  end

  // split into sign and magnitude, numerator pre-shifted for the divider
  logic [SW-1:0] mre, mim;
  assign mre = s_re_q[SW-1] ? SW'(-s_re_q) : SW'(s_re_q);
  assign mim = s_im_q[SW-1] ? SW'(-s_im_q) : SW'(s_im_q);

  // row of division cells, sign/op carried alongside
  logic [NW-1:0] nre [NS+1];
  logic [NW-1:0] nim [NS+1];
  logic [DW-1:0] rre [NS+1];
  logic [DW-1:0] rim [NS+1];
  logic [DW-1:0] den [NS+1];
  logic [1:0]    opc_q [NS];
  logic          sre_q [NS];
  logic          sim_q [NS];
  logic [SW-1:0] raw_re_q [NS];
  logic [SW-1:0] raw_im_q [NS];

  assign nre[0] = {mre[PW-1:0], {FRAC_BITS{1'b0}}};
  assign nim[0] = {mim[PW-1:0], {FRAC_BITS{1'b0}}};
  assign rre[0] = '0;
  assign rim[0] = '0;
  assign den[0] = den2_q;

  // side registers travelling in step with the cells
  always_ff @(posedge clk_i) begin
    if (adv) begin
      opc_q[0]    <= op2_q;
      sre_q[0]    <= s_re_q[SW-1];
      sim_q[0]    <= s_im_q[SW-1];
      raw_re_q[0] <= s_re_q;
      raw_im_q[0] <= s_im_q;
      for (int k = 1; k < NS; k++) begin
        opc_q[k]    <= opc_q[k-1];
        sre_q[k]    <= sre_q[k-1];
        sim_q[k]    <= sim_q[k-1];
        raw_re_q[k] <= raw_re_q[k-1];
        raw_im_q[k] <= raw_im_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_cell
    // first cell sees combinational stage-2 input; register it via cell itself
    cau_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .nre_i (nre[g]),
      .nim_i (nim[g]),
      .rre_i (rre[g]),
      .rim_i (rim[g]),
      .den_i (den[g]),
      .nre_o (nre[g+1]),
      .nim_o (nim[g+1]),
      .rre_o (rre[g+1]),
      .rim_o (rim[g+1]),
      .den_o (den[g+1])
    );
  end

  // final selection, sign restore and saturation
  localparam int unsigned XW = NW + 2;
  logic [1:0] opf;
  logic signed [XW-1:0] vre, vim;
  logic [NW-1:0] qre, qim;
  logic [SW-1:0] mag_re, mag_im;
  logic dz;
  assign opf = opc_q[NS-1];
  assign dz  = (opf == cau_pkg::OP_DIV) && (den[NS] == '0);
  assign qre = nre[NS];
  assign qim = nim[NS];
  assign mag_re = raw_re_q[NS-1][SW-1] ? SW'(-raw_re_q[NS-1]) : raw_re_q[NS-1];
  assign mag_im = raw_im_q[NS-1][SW-1] ? SW'(-raw_im_q[NS-1]) : raw_im_q[NS-1];

  always_comb begin
    unique case (cau_pkg::op_e'(opf))
      cau_pkg::OP_DIV: begin
        vre = sre_q[NS-1] ? -XW'(qre) : XW'(qre);
        vim = sim_q[NS-1] ? -XW'(qim) : XW'(qim);
      end
      cau_pkg::OP_MUL: begin
        // magnitude shift toward zero
        vre = raw_re_q[NS-1][SW-1] ? -XW'(mag_re >> FRAC_BITS) : XW'(mag_re >> FRAC_BITS);
        vim = raw_im_q[NS-1][SW-1] ? -XW'(mag_im >> FRAC_BITS) : XW'(mag_im >> FRAC_BITS);
      end
      default: begin
        vre = XW'(signed'(raw_re_q[NS-1]));
        vim = XW'(signed'(raw_im_q[NS-1]));
      end
    endcase
    if (dz) begin
      vre = '0;
      vim = '0;
    end
  end

  localparam logic signed [XW-1:0] VMAX = XW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [XW-1:0] VMIN = -XW'(64'd1 << (W - 1));

  logic ore, oim;
  logic [W-1:0] rre_s, rim_s;
  always_comb begin
    ore = (vre > VMAX) || (vre < VMIN);
    oim = (vim > VMAX) || (vim < VMIN);
    rre_s = (vre > VMAX) ? VMAX[W-1:0] : (vre < VMIN) ? VMIN[W-1:0] : vre[W-1:0];
    rim_s = (vim > VMAX) ? VMAX[W-1:0] : (vim < VMIN) ? VMIN[W-1:0] : vim[W-1:0];
  end

  // output register
  logic [2*W+1:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {ore | oim, dz, rim_s, rre_s};
  end
  assign out_o.data = out_q;

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], in_i.valid};
    end
  end
  assign out_o.valid = vld_q[L-1];

  // assertions
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_q[2*W] |-> out_q[2*W-1:0] == '0 && !out_q[2*W+1])
    else $error("div_zero result not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_q))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");
endmodule
`default_nettype wire

FILE: sv/cau_div_cell.sv
// one restoring-division cell: one quotient bit for both parts per stage
// depends on nothing
`default_nettype none
module cau_div_cell #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] nre_i,
  input  wire logic [NW-1:0] nim_i,
  input  wire logic [DW-1:0] rre_i,
  input  wire logic [DW-1:0] rim_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] nre_o,
  output logic      [NW-1:0] nim_o,
  output logic      [DW-1:0] rre_o,
  output logic      [DW-1:0] rim_o,
  output logic      [DW-1:0] den_o
);
  logic [DW:0] tre, tim;
  logic [DW-1:0] rre_d, rim_d;
  logic [NW-1:0] nre_d, nim_d;

  // shift in next numerator bit, subtract when it fits, quotient bit into numerator lsb
  always_comb begin
    tre = {rre_i, nre_i[NW-1]};
    tim = {rim_i, nim_i[NW-1]};
    nre_d = {nre_i[NW-2:0], 1'b0};
    nim_d = {nim_i[NW-2:0], 1'b0};
    if (tre >= {1'b0, den_i}) begin
      tre = tre - {1'b0, den_i};
      nre_d[0] = 1'b1;
    end
    if (tim >= {1'b0, den_i}) begin
      tim = tim - {1'b0, den_i};
      nim_d[0] = 1'b1;
    end
    rre_d = tre[DW-1:0];
    rim_d = tim[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nre_o <= nre_d;
      nim_o <= nim_d;
      rre_o <= rre_d;
      rim_o <= rim_d;
      den_o <= den_i;
    end
  end
endmodule
`default_nettype wire
